/* hdl/handle_table_allocator_defines.svh */
// Assertion macros shared by the handle table allocator modules.
// Each macro expects the using module to have clk and rst_n in scope.
`ifndef HANDLE_TABLE_ALLOCATOR_DEFINES_SVH
`define HANDLE_TABLE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/hta_pkg.sv */
// Shared types and constants for the handle table allocator.
// Has no dependencies; every other module imports it.
`default_nettype none

package hta_pkg;

  localparam int REQ_W  = 2;
  localparam int SYS_W  = 16;
  localparam int IDX_W  = 8;
  localparam int STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_OPEN   = 2'd0,
    REQ_CLOSE  = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_REUSED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOT_OPEN = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming request word
    logic eval;     // register the match vector
    logic commit;   // update the table and load the result register
  } hta_cmd_t;

endpackage

`default_nettype wire

/* hdl/hta_ctrl.sv */
// Controller for the handle table allocator: sequencing FSM and output valid.
// Depends on hta_pkg and handle_table_allocator_defines.svh.
`default_nettype none
`include "handle_table_allocator_defines.svh"

module hta_ctrl
  import hta_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hta_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EVAL   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   commit;
  logic   accept;

  // The result register can be loaded when empty or when its word leaves now.
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_DECIDE) && out_free;
  assign in_ready = (state_r == ST_IDLE) || commit;
  assign accept   = in_valid && in_ready;

  assign cmd.capture = accept;
  assign cmd.eval    = (state_r == ST_EVAL);
  assign cmd.commit  = commit;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (commit) state_nxt = accept ? ST_EVAL : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `HTA_ASSERT_NEXT(a_accept_to_eval, accept, state_r == ST_EVAL,
                   "accepted word did not move to evaluation")
  `HTA_ASSERT_NEXT(a_commit_fills_out, commit, out_valid_r,
                   "committed result not presented")
  `HTA_ASSERT_NOW(a_no_commit_on_busy_out, out_valid_r && !out_ready, !commit,
                  "result overwritten while still pending")

endmodule

`default_nettype wire

/* hdl/hta_datapath.sv */
// Datapath for the handle table allocator: slot table, match vector,
// priority encoders and result register. Depends on hta_pkg and the defines header.
`default_nettype none
`include "handle_table_allocator_defines.svh"

module hta_datapath
  import hta_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hta_cmd_t          cmd,
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [SYS_W-1:0]  in_sys_handle,
  input  wire logic [IDX_W-1:0]  in_slot_index,
  output logic [STAT_W-1:0]      out_status,
  output logic [IDX_W-1:0]       out_slot_out,
  output logic [SYS_W-1:0]       out_sys_out
);

  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam logic [TABLE_DEPTH-1:0] VALID_RST = TABLE_DEPTH'(3);

  // Request word
  logic [REQ_W-1:0]       req_r;
  logic [HANDLE_BITS-1:0] want_r;
  logic [IDX_W-1:0]       idx_r;
  logic [HANDLE_BITS-1:0] want_in;

  // Slot table
  logic [TABLE_DEPTH-1:0] slot_valid_r;
  logic [HANDLE_BITS-1:0] handle_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_r, match_nxt;

  // Decision
  logic                   hit;
  logic [SLOT_W-1:0]      hit_idx;
  logic                   free_any;
  logic [SLOT_W-1:0]      free_idx;
  logic                   in_range;
  logic [SLOT_W-1:0]      slot_sel;
  logic                   sel_valid;
  logic [HANDLE_BITS-1:0] sel_handle;
  logic [SYS_W-1:0]       sel_sys;
  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_idx;
  logic                   wr_valid;
  logic [HANDLE_BITS-1:0] wr_handle;
  status_t                res_status;
  logic [IDX_W-1:0]       res_slot;
  logic [SYS_W-1:0]       res_sys;

  // Result register
  status_t                res_status_r;
  logic [IDX_W-1:0]       res_slot_r;
  logic [SYS_W-1:0]       res_sys_r;

  // Fit the 16-bit handle field to the stored handle width and back.
  generate
    if (HANDLE_BITS >= SYS_W) begin : g_wide
      assign want_in = HANDLE_BITS'(in_sys_handle);
      assign sel_sys = sel_handle[SYS_W-1:0];
    end else begin : g_narrow
      assign want_in = in_sys_handle[HANDLE_BITS-1:0];
      assign sel_sys = {{(SYS_W-HANDLE_BITS){1'b0}}, sel_handle};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req_type;
      want_r <= want_in;
      idx_r  <= in_slot_index;
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_nxt[i] = slot_valid_r[i] && (handle_r[i] == want_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) match_r <= match_nxt;
  end

  // Highest matching slot and lowest free slot.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match_r[i]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign in_range   = ((IDX_W + 1)'(idx_r) < (IDX_W + 1)'(TABLE_DEPTH));
  assign slot_sel   = idx_r[SLOT_W-1:0];
  assign sel_valid  = in_range && slot_valid_r[slot_sel];
  assign sel_handle = handle_r[slot_sel];

  always_comb begin
    res_status = ST_NOT_OPEN;
    res_slot   = '0;
    res_sys    = '0;
    wr_en      = 1'b0;
    wr_idx     = slot_sel;
    wr_valid   = 1'b0;
    wr_handle  = '0;
    unique case (req_r)
      REQ_OPEN: begin
        if (hit) begin
          res_status = ST_REUSED;
          res_slot   = IDX_W'(hit_idx);
        end else if (free_any) begin
          res_status = ST_DONE;
          res_slot   = IDX_W'(free_idx);
          wr_en      = 1'b1;
          wr_idx     = free_idx;
          wr_valid   = 1'b1;
          wr_handle  = want_r;
        end else begin
          res_status = ST_FULL;
        end
      end
      REQ_CLOSE, REQ_LOOKUP: begin
        if (sel_valid) begin
          res_status = ST_DONE;
          res_sys    = sel_sys;
          // A close frees the slot and clears its stored handle.
          wr_en      = (req_r == REQ_CLOSE);
        end
      end
      default: begin
        res_status = ST_NOT_OPEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= VALID_RST;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        handle_r[i] <= (i == 1) ? HANDLE_BITS'(1) : '0;
      end
    end else if (cmd.commit && wr_en) begin
      slot_valid_r[wr_idx] <= wr_valid;
      handle_r[wr_idx]     <= wr_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r <= res_status;
      res_slot_r   <= res_slot;
      res_sys_r    <= res_sys;
    end
  end

  assign out_status   = res_status_r;
  assign out_slot_out = res_slot_r;
  assign out_sys_out  = res_sys_r;

  `HTA_ASSERT_NEXT(a_match_only_valid, cmd.eval, (match_r & ~slot_valid_r) == '0,
                   "match vector flags a free slot")
  `HTA_ASSERT_NEXT(a_grant_sets_valid,
                   cmd.commit && wr_en && wr_valid, slot_valid_r[$past(free_idx)],
                   "granted slot not marked open")
  `HTA_ASSERT_NOW(a_hit_not_written, cmd.commit && hit && (req_r == REQ_OPEN), !wr_en,
                  "reused slot must leave the table unchanged")

endmodule

`default_nettype wire

/* hdl/handle_table_allocator.sv */
// Top level of the handle table allocator: joins controller and datapath.
// Depends on hta_pkg, hta_ctrl and hta_datapath.
//
//   channel   ports                                          direction
//   input     in_valid/in_ready, in_req_type, in_sys_handle,   in
//             in_slot_index
//   result    out_valid/out_ready, out_status, out_slot_out,   out
//             out_sys_out
//
// Each word is captured, then the match vector of all slots is registered, then the
// vector is priority-encoded, the slot table updated and the result register loaded.
// A new word is accepted in the same cycle the previous one commits.
// Reset is synchronous, active low; slots 0 and 1 come back open holding 0 and 1.
// A pending result holds the commit step until out_ready frees the result register.
`default_nettype none

module handle_table_allocator
  import hta_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [SYS_W-1:0]  in_sys_handle,
  input  wire logic [IDX_W-1:0]  in_slot_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      out_status,
  output logic [IDX_W-1:0]       out_slot_out,
  output logic [SYS_W-1:0]       out_sys_out
);

  hta_cmd_t cmd;

  hta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  hta_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_req_type   (in_req_type),
    .in_sys_handle (in_sys_handle),
    .in_slot_index (in_slot_index),
    .out_status    (out_status),
    .out_slot_out  (out_slot_out),
    .out_sys_out   (out_sys_out)
  );

endmodule

`default_nettype wire
